### rtl/rcst_pkg.sv
// shared types and constants for the stick channel trim processor
// no dependencies; used by rcst_ctrl, rcst_datapath and the top level
`timescale 1ns / 1ps

package rcst_pkg;

    localparam int CH_COUNT  = 4;
    localparam int DIV_STEPS = 3;   // pipelined reciprocal divide steps, 36 bit dividend
    localparam int DIVIDEND_W = 36;

    // key actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_A     = 3'd1;
    localparam logic [2:0] ACT_B     = 3'd2;
    localparam logic [2:0] ACT_C     = 3'd3;
    localparam logic [2:0] ACT_D     = 3'd4;
    localparam logic [2:0] ACT_E     = 3'd5;
    localparam logic [2:0] ACT_LOAD  = 3'd6;

    // modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_STICK = 2'd1;
    localparam logic [1:0] MODE_TILT  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_START_MODE = 3'd0;
    localparam logic [2:0] REG_TRIM_ROLL  = 3'd1;
    localparam logic [2:0] REG_TRIM_PITCH = 3'd2;
    localparam logic [2:0] REG_TRIM_YAW   = 3'd3;
    localparam logic [2:0] REG_TRIM_THR   = 3'd4;

    localparam logic [10:0] AUX_LOW  = 11'd1100;
    localparam logic [10:0] AUX_HIGH = 11'd1500;

    typedef struct packed {
        logic       capture;
        logic       div_load;
        logic       div_step;
        logic       scale;
        logic       finish;
        logic [1:0] ch;
    } rcst_cmd_t;

    typedef struct packed {
        logic out_free;
    } rcst_status_t;

endpackage

### rtl/rcst_ctrl.sv
// sequencer for the stick channel trim processor
// depends on rcst_pkg
`timescale 1ns / 1ps

module rcst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rcst_pkg::rcst_status_t status,
    output rcst_pkg::rcst_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 2'd0;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.ch       = ch_reg;
        in_stall     = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    ch_next     = 2'd0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = 3'd0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'(rcst_pkg::DIV_STEPS - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
                if (ch_reg == 2'(rcst_pkg::CH_COUNT - 1))
                    state_next = ST_FINISH;
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/rcst_datapath.sv
// filters, divider, scaler, key decoder, trims and result register
// depends on rcst_pkg
`timescale 1ns / 1ps

module rcst_datapath #(
    parameter int KEY_DELAY_TICKS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rcst_pkg::rcst_cmd_t     cmd,
    output rcst_pkg::rcst_status_t  status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [9:0]             cfg_data,
    input  logic [11:0]            adc_roll,
    input  logic [11:0]            adc_pitch,
    input  logic [11:0]            adc_yaw,
    input  logic [11:0]            adc_throttle,
    input  logic [11:0]            adc_key_left,
    input  logic [11:0]            adc_key_right,
    input  logic signed [11:0]     tilt_x_tenths,
    input  logic signed [11:0]     tilt_y_tenths,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [11:0]            out_roll,
    output logic [11:0]            out_pitch,
    output logic [11:0]            out_yaw,
    output logic [11:0]            out_throttle,
    output logic [10:0]            out_aux1,
    output logic [10:0]            out_aux2,
    output logic [1:0]             out_mode,
    output logic                   trim_changed
);

    localparam int DW = rcst_pkg::DIVIDEND_W;

    // reciprocals for the divide by 100
    localparam logic [18:0] RECIP_HI = 19'd335545;    // ceil(2^25 / 100)
    localparam logic [25:0] RECIP_LO = 26'd42949673;  // ceil(2^32 / 100)

    // captured item
    logic [11:0]        x_reg [rcst_pkg::CH_COUNT];
    logic [11:0]        kl_reg, kr_reg;
    logic signed [11:0] tx_reg, ty_reg;

    // state
    logic [27:0]        y_reg   [rcst_pkg::CH_COUNT];
    logic [11:0]        chv_reg [rcst_pkg::CH_COUNT];
    logic signed [9:0]  trim_reg [rcst_pkg::CH_COUNT];
    logic signed [9:0]  trim_next [rcst_pkg::CH_COUNT];
    logic               aux1_reg, aux1_next, aux2_reg, aux2_next;
    logic [1:0]         mode_reg, mode_next;
    logic               armed_reg;
    logic [3:0]         cd_reg;

    // divider
    logic [DW-1:0]      num_reg;
    logic [11:0]        qh_reg;
    logic [24:0]        lo_reg;
    logic [27:0]        quo_reg;
    logic [36:0]        qh_prod;
    logic [6:0]         rem_hi;
    logic [50:0]        ql_prod;

    // result register
    logic               ov_reg;
    logic [11:0]        o_ch_reg [rcst_pkg::CH_COUNT];
    logic               o_aux1_reg, o_aux2_reg, o_chg_reg;
    logic [1:0]         o_mode_reg;

    assign status.out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg[0] <= adc_roll;
            x_reg[1] <= adc_pitch;
            x_reg[2] <= adc_yaw;
            x_reg[3] <= adc_throttle;
            kl_reg   <= adc_key_left;
            kr_reg   <= adc_key_right;
            tx_reg   <= tilt_x_tenths;
            ty_reg   <= tilt_y_tenths;
        end
    end

    // divide by 100 in three pipelined steps: upper 18 bits give the high
    // quotient, their remainder joined with the lower 18 bits the low quotient
    assign qh_prod = 37'(num_reg[DW-1:18]) * 37'(RECIP_HI);
    assign rem_hi  = 7'(num_reg[DW-1:18] - 18'(qh_reg) * 18'd100);
    assign ql_prod = 51'(lo_reg) * 51'(RECIP_LO);

    logic [34:0] prod99;
    assign prod99 = 35'(y_reg[cmd.ch]) * 35'd99;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
            num_reg <= DW'(prod99) + DW'({x_reg[cmd.ch], 16'd0});
        else if (cmd.div_step)
        begin
            qh_reg  <= qh_prod[36:25];
            lo_reg  <= {rem_hi, num_reg[17:0]};
            quo_reg <= {qh_reg[9:0], ql_prod[49:32]};
        end
    end

    // scaling of the channel just filtered
    logic [27:0]        yq;
    logic [10:0]        y_hi;
    logic               y_frac;
    logic signed [13:0] base, d_stick, d_tilt, d_sel;
    logic signed [11:0] tilt_sel;
    logic signed [24:0] prod;
    logic signed [15:0] sum;
    logic [11:0]        scaled;
    logic               use_tilt, hold;

    assign yq     = quo_reg;
    assign y_hi   = yq[27:17];
    assign y_frac = (yq[16:0] != 17'd0);

    always_comb
    begin
        if (!cmd.ch[0])
            base = 14'sd2000 - $signed({3'b0, y_hi})
                 - $signed({13'b0, (y_frac && (y_hi < 11'd2000))});
        else
            base = $signed({3'b0, y_hi}) + 14'sd1000;
        d_stick  = base - 14'(trim_reg[cmd.ch]) - 14'sd1500;
        tilt_sel = cmd.ch[0] ? ty_reg : tx_reg;
        if (tilt_sel < -12'sd500)
            d_tilt = -14'sd500;
        else if (tilt_sel > 12'sd500)
            d_tilt = 14'sd500;
        else
            d_tilt = 14'(tilt_sel);
        use_tilt = !cmd.ch[1] && (mode_reg == rcst_pkg::MODE_TILT);
        hold     = !cmd.ch[1] && (mode_reg != rcst_pkg::MODE_TILT)
                 && (mode_reg != rcst_pkg::MODE_STICK);
        d_sel    = use_tilt ? d_tilt : d_stick;
        prod     = 25'(d_sel) * 25'sd922;
        sum      = 16'($signed(prod[24:10])) + 16'sd1500;
        if (sum < 16'sd0)
            scaled = 12'd0;
        else if (sum > 16'sd4095)
            scaled = 12'd4095;
        else
            scaled = sum[11:0];
    end

    // key decoding
    function automatic logic [2:0] left_act(input logic [11:0] k);
        logic [2:0] a;
        a = rcst_pkg::ACT_NONE;
        if (k < 12'd100)                         a = rcst_pkg::ACT_A;
        else if (k > 12'd1950 && k < 12'd2100)   a = rcst_pkg::ACT_B;
        else if (k > 12'd2650 && k < 12'd2750)   a = rcst_pkg::ACT_C;
        else if (k > 12'd3000 && k < 12'd3100)   a = rcst_pkg::ACT_D;
        else if (k > 12'd3200 && k < 12'd3300)   a = rcst_pkg::ACT_E;
        return a;
    endfunction

    function automatic logic [2:0] right_act(input logic [11:0] k);
        logic [2:0] a;
        a = rcst_pkg::ACT_NONE;
        if (k < 12'd100)                         a = rcst_pkg::ACT_A;
        else if (k > 12'd1900 && k < 12'd2100)   a = rcst_pkg::ACT_B;
        else if (k > 12'd2600 && k < 12'd2800)   a = rcst_pkg::ACT_C;
        else if (k > 12'd2950 && k < 12'd3150)   a = rcst_pkg::ACT_D;
        else if (k > 12'd3200 && k < 12'd3300)   a = rcst_pkg::ACT_E;
        else if (k > 12'd3350 && k < 12'd3450)   a = rcst_pkg::ACT_LOAD;
        return a;
    endfunction

    function automatic logic signed [9:0] trim_add(input logic signed [9:0] t,
                                                   input logic up);
        logic signed [10:0] s;
        s = up ? 11'(t) + 11'sd2 : 11'(t) - 11'sd2;
        if (s > 11'sd500)
            s = 11'sd500;
        else if (s < -11'sd500)
            s = -11'sd500;
        return s[9:0];
    endfunction

    logic [3:0] cd_next;
    logic       armed_next, changed;
    logic [2:0] la, ra;

    always_comb
    begin
        cd_next    = cd_reg;
        armed_next = armed_reg;
        changed    = 1'b0;
        mode_next  = mode_reg;
        aux1_next  = aux1_reg;
        aux2_next  = aux2_reg;
        for (int i = 0; i < rcst_pkg::CH_COUNT; i++)
            trim_next[i] = trim_reg[i];
        la = left_act(kl_reg);
        ra = right_act(kr_reg);
        if (cd_next != 4'd0)
            cd_next = cd_next - 4'd1;
        if (armed_next && la != rcst_pkg::ACT_NONE)
        begin
            if (cd_next == 4'd0)
                cd_next = 4'(KEY_DELAY_TICKS);
            if (cd_next == 4'd1)
            begin
                armed_next = 1'b0;
                case (la)
                    rcst_pkg::ACT_A:
                    begin
                        trim_next[3] = trim_add(trim_reg[3], 1'b0);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_B:
                    begin
                        trim_next[2] = trim_add(trim_reg[2], 1'b1);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_C:
                    begin
                        trim_next[3] = trim_add(trim_reg[3], 1'b1);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_D:
                    begin
                        trim_next[2] = trim_add(trim_reg[2], 1'b0);
                        changed = 1'b1;
                    end
                    default:
                    begin
                        if (mode_reg == rcst_pkg::MODE_STICK)
                            mode_next = rcst_pkg::MODE_TILT;
                        else if (mode_reg == rcst_pkg::MODE_TILT)
                            mode_next = rcst_pkg::MODE_STICK;
                        aux1_next = !aux1_reg;
                    end
                endcase
            end
        end
        if (armed_next && ra != rcst_pkg::ACT_NONE)
        begin
            if (cd_next == 4'd0)
                cd_next = 4'(KEY_DELAY_TICKS);
            if (cd_next == 4'd1 && ra != rcst_pkg::ACT_LOAD)
            begin
                armed_next = 1'b0;
                case (ra)
                    rcst_pkg::ACT_A:
                    begin
                        trim_next[1] = trim_add(trim_reg[1], 1'b0);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_B:
                    begin
                        trim_next[0] = trim_add(trim_reg[0], 1'b0);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_C:
                    begin
                        trim_next[1] = trim_add(trim_reg[1], 1'b1);
                        changed = 1'b1;
                    end
                    rcst_pkg::ACT_D:
                    begin
                        trim_next[0] = trim_add(trim_reg[0], 1'b1);
                        changed = 1'b1;
                    end
                    default:
                    begin
                        aux2_next = !aux2_reg;
                    end
                endcase
            end
        end
        if (kl_reg > 12'd4050 && kr_reg > 12'd4050)
            armed_next = 1'b1;
    end

    // configured trim, limited to +-500
    logic signed [9:0] cfg_trim;
    always_comb
    begin
        if ($signed(cfg_data) > 10'sd500)
            cfg_trim = 10'sd500;
        else if ($signed(cfg_data) < -10'sd500)
            cfg_trim = -10'sd500;
        else
            cfg_trim = $signed(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg[0]  <= 28'(1500) << 16;
            y_reg[1]  <= 28'(1500) << 16;
            y_reg[2]  <= 28'(1500) << 16;
            y_reg[3]  <= 28'd0;
            for (int i = 0; i < rcst_pkg::CH_COUNT; i++)
            begin
                chv_reg[i]  <= 12'd0;
                trim_reg[i] <= 10'sd0;
            end
            aux1_reg  <= 1'b0;
            aux2_reg  <= 1'b0;
            mode_reg  <= rcst_pkg::MODE_STICK;
            armed_reg <= 1'b0;
            cd_reg    <= 4'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scale)
            begin
                y_reg[cmd.ch] <= yq;
                if (!hold)
                    chv_reg[cmd.ch] <= scaled;
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < rcst_pkg::CH_COUNT; i++)
                    trim_reg[i] <= trim_next[i];
                aux1_reg  <= aux1_next;
                aux2_reg  <= aux2_next;
                mode_reg  <= mode_next;
                armed_reg <= armed_next;
                cd_reg    <= cd_next;
            end
            else if (cfg_we)
            begin
                if (cfg_index == rcst_pkg::REG_START_MODE)
                    mode_reg <= (cfg_data[1:0] > rcst_pkg::MODE_TILT)
                              ? rcst_pkg::MODE_NONE : cfg_data[1:0];
                else if (cfg_index >= rcst_pkg::REG_TRIM_ROLL
                         && cfg_index <= rcst_pkg::REG_TRIM_THR)
                    trim_reg[2'(cfg_index - rcst_pkg::REG_TRIM_ROLL)] <= cfg_trim;
            end
            if (cmd.finish)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int i = 0; i < rcst_pkg::CH_COUNT; i++)
                o_ch_reg[i] <= chv_reg[i];
            o_aux1_reg <= aux1_next;
            o_aux2_reg <= aux2_next;
            o_mode_reg <= mode_next;
            o_chg_reg  <= changed;
        end
    end

    assign out_valid    = ov_reg;
    assign out_roll     = o_ch_reg[0];
    assign out_pitch    = o_ch_reg[1];
    assign out_yaw      = o_ch_reg[2];
    assign out_throttle = o_ch_reg[3];
    assign out_aux1     = o_aux1_reg ? rcst_pkg::AUX_HIGH : rcst_pkg::AUX_LOW;
    assign out_aux2     = o_aux2_reg ? rcst_pkg::AUX_HIGH : rcst_pkg::AUX_LOW;
    assign out_mode     = o_mode_reg;
    assign trim_changed = o_chg_reg;

endmodule

### rtl/rc_stick_channel_trim_processor.sv
// top level of the stick channel trim processor
// depends on rcst_pkg, rcst_ctrl and rcst_datapath
`timescale 1ns / 1ps

// usage
// - one input transfer per control tick: four stick samples, two key ladder
//   samples and two tilt angles; one result transfer per input transfer
// - input side: in_valid / in_stall; in_stall is high while a tick is in work
// - output side: out_valid / out_stall; the result sits in an output register,
//   so the next tick is taken while a finished result still waits
// - sequence: per channel one load step, three pipelined steps of the shared
//   divide-by-100 unit (two reciprocal multiplies) and one scaling step, then
//   one key handling step
// - a new tick is taken only after the previous one is through, since the
//   single shared divider walks the four filter channels in turn; the idle
//   step takes the next transfer
// - a stalled receiver holds the finished tick in the key handling step, so a
//   second tick waits there until the output register frees up
// - reset: filters at 1500 (throttle 0), trims 0, stick mode, aux low, keys
//   disarmed; config writes (cfg_we, cfg_index, cfg_data) load mode and trims
//   directly; user makes them only while the block is idle, not enforced here
// - KEY_DELAY_TICKS: ticks a key must be held before its action fires

module rc_stick_channel_trim_processor #(
    parameter int KEY_DELAY_TICKS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        adc_roll,
    input  logic [11:0]        adc_pitch,
    input  logic [11:0]        adc_yaw,
    input  logic [11:0]        adc_throttle,
    input  logic [11:0]        adc_key_left,
    input  logic [11:0]        adc_key_right,
    input  logic signed [11:0] tilt_x_tenths,
    input  logic signed [11:0] tilt_y_tenths,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        out_roll,
    output logic [11:0]        out_pitch,
    output logic [11:0]        out_yaw,
    output logic [11:0]        out_throttle,
    output logic [10:0]        out_aux1,
    output logic [10:0]        out_aux2,
    output logic [1:0]         out_mode,
    output logic               trim_changed
);

    rcst_pkg::rcst_cmd_t    cmd;
    rcst_pkg::rcst_status_t status;

    // sequencer: walks the channels through load, divide and scale
    rcst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: filter state, divider, scaler, keys and result register
    rcst_datapath #(
        .KEY_DELAY_TICKS (KEY_DELAY_TICKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .adc_roll      (adc_roll),
        .adc_pitch     (adc_pitch),
        .adc_yaw       (adc_yaw),
        .adc_throttle  (adc_throttle),
        .adc_key_left  (adc_key_left),
        .adc_key_right (adc_key_right),
        .tilt_x_tenths (tilt_x_tenths),
        .tilt_y_tenths (tilt_y_tenths),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_roll      (out_roll),
        .out_pitch     (out_pitch),
        .out_yaw       (out_yaw),
        .out_throttle  (out_throttle),
        .out_aux1      (out_aux1),
        .out_aux2      (out_aux2),
        .out_mode      (out_mode),
        .trim_changed  (trim_changed)
    );

endmodule

### tb/sv/rc_stick_channel_trim_processor_tb.sv
// testbench for the stick channel trim processor: random and directed ticks
// checked against an in-bench predictor; depends on rcst_pkg and the rtl
`timescale 1ns / 1ps

module rc_stick_channel_trim_processor_tb;

    localparam int KEY_DELAY = 10;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [11:0] roll, pitch, yaw, thr, kl, kr;
        logic signed [11:0] tx, ty;
    } tick_t;

    typedef struct packed {
        logic [11:0] roll, pitch, yaw, thr;
        logic [10:0] aux1, aux2;
        logic [1:0]  mode;
        logic        changed;
    } frame_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    tick_t cur;
    frame_t got;

    rc_stick_channel_trim_processor #(.KEY_DELAY_TICKS(KEY_DELAY)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .adc_roll(cur.roll), .adc_pitch(cur.pitch), .adc_yaw(cur.yaw),
        .adc_throttle(cur.thr), .adc_key_left(cur.kl), .adc_key_right(cur.kr),
        .tilt_x_tenths(cur.tx), .tilt_y_tenths(cur.ty),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_roll(got.roll), .out_pitch(got.pitch), .out_yaw(got.yaw),
        .out_throttle(got.thr), .out_aux1(got.aux1), .out_aux2(got.aux2),
        .out_mode(got.mode), .trim_changed(got.changed)
    );

    // predictor state
    logic [35:0] filt [4];
    int chan_val [4];
    int trim [4];
    bit aux1_hi, aux2_hi, armed;
    logic [1:0] mode_now;
    int countdown;

    tick_t  tick_queue[$];
    frame_t frame_queue[$];
    int mismatches = 0;
    int ticks_sent = 0;
    int frames_seen = 0;
    int trim_pulses = 0;
    bit src_wait_on;   // source-side gaps are switched off during register writes

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // (d)*0.9 rounded toward minus infinity, recentered and saturated
    function automatic int pulse_scale(int d);
        int m;
        m = d * 922;
        return clamp((m >>> 10) + 1500, 0, 4095);
    endfunction

    function automatic int stick_norm(logic [35:0] y);
        return int'(y >> 17) + 1000;
    endfunction

    // 2000 - y/2, truncated toward zero
    function automatic int stick_inv(logic [35:0] y);
        longint t;
        t = (longint'(2000) <<< 17) - longint'(y);
        return t >= 0 ? int'(t >>> 17) : -int'((-t) >>> 17);
    endfunction

    task automatic reset_model();
        for (int i = 0; i < 4; i++)
        begin
            trim[i] = 0;
            chan_val[i] = 0;
            filt[i] = (i == 3) ? 36'd0 : (36'd1500 << 16);
        end
        aux1_hi = 0;
        aux2_hi = 0;
        mode_now = rcst_pkg::MODE_STICK;
        armed = 0;
        countdown = 0;
    endtask

    function automatic bit key_fire();
        if (countdown == 0)
            countdown = KEY_DELAY;
        return countdown == 1;
    endfunction

    function automatic void bump_trim(int ch, int d, ref bit chg);
        trim[ch] = clamp(trim[ch] + d, -500, 500);
        chg = 1;
    endfunction

    function automatic frame_t predict_frame(tick_t t);
        frame_t f;
        bit chg;
        logic [11:0] raw [4];
        logic [2:0] act;
        chg = 0;
        raw[0] = t.roll; raw[1] = t.pitch; raw[2] = t.yaw; raw[3] = t.thr;
        for (int i = 0; i < 4; i++)
            filt[i] = (filt[i] * 99 + (36'(raw[i]) << 16)) / 100;
        if (mode_now == rcst_pkg::MODE_STICK)
        begin
            chan_val[0] = pulse_scale(stick_inv(filt[0]) - trim[0] - 1500);
            chan_val[1] = pulse_scale(stick_norm(filt[1]) - trim[1] - 1500);
        end
        else if (mode_now == rcst_pkg::MODE_TILT)
        begin
            chan_val[0] = pulse_scale(clamp(int'(t.tx), -500, 500));
            chan_val[1] = pulse_scale(clamp(int'(t.ty), -500, 500));
        end
        chan_val[2] = pulse_scale(stick_inv(filt[2]) - trim[2] - 1500);
        chan_val[3] = pulse_scale(stick_norm(filt[3]) - trim[3] - 1500);
        if (countdown != 0)
            countdown--;
        if (armed)
        begin
            act = rcst_pkg::ACT_NONE;
            if (t.kl < 100) act = rcst_pkg::ACT_A;
            else if (t.kl > 1950 && t.kl < 2100) act = rcst_pkg::ACT_B;
            else if (t.kl > 2650 && t.kl < 2750) act = rcst_pkg::ACT_C;
            else if (t.kl > 3000 && t.kl < 3100) act = rcst_pkg::ACT_D;
            else if (t.kl > 3200 && t.kl < 3300) act = rcst_pkg::ACT_E;
            if (act != rcst_pkg::ACT_NONE && key_fire())
            begin
                case (act)
                    rcst_pkg::ACT_A: bump_trim(3, -2, chg);
                    rcst_pkg::ACT_B: bump_trim(2, 2, chg);
                    rcst_pkg::ACT_C: bump_trim(3, 2, chg);
                    rcst_pkg::ACT_D: bump_trim(2, -2, chg);
                    default:
                    begin
                        if (mode_now == rcst_pkg::MODE_STICK)
                            mode_now = rcst_pkg::MODE_TILT;
                        else if (mode_now == rcst_pkg::MODE_TILT)
                            mode_now = rcst_pkg::MODE_STICK;
                        aux1_hi = !aux1_hi;
                    end
                endcase
                armed = 0;
            end
        end
        if (armed)
        begin
            act = rcst_pkg::ACT_NONE;
            if (t.kr < 100) act = rcst_pkg::ACT_A;
            else if (t.kr > 1900 && t.kr < 2100) act = rcst_pkg::ACT_B;
            else if (t.kr > 2600 && t.kr < 2800) act = rcst_pkg::ACT_C;
            else if (t.kr > 2950 && t.kr < 3150) act = rcst_pkg::ACT_D;
            else if (t.kr > 3200 && t.kr < 3300) act = rcst_pkg::ACT_E;
            else if (t.kr > 3350 && t.kr < 3450) act = rcst_pkg::ACT_LOAD;
            if (act != rcst_pkg::ACT_NONE && key_fire() && act != rcst_pkg::ACT_LOAD)
            begin
                case (act)
                    rcst_pkg::ACT_A: bump_trim(1, -2, chg);
                    rcst_pkg::ACT_B: bump_trim(0, -2, chg);
                    rcst_pkg::ACT_C: bump_trim(1, 2, chg);
                    rcst_pkg::ACT_D: bump_trim(0, 2, chg);
                    default: aux2_hi = !aux2_hi;
                endcase
                armed = 0;
            end
        end
        if (t.kl > 4050 && t.kr > 4050)
            armed = 1;
        f.roll = chan_val[0][11:0];
        f.pitch = chan_val[1][11:0];
        f.yaw = chan_val[2][11:0];
        f.thr = chan_val[3][11:0];
        f.aux1 = aux1_hi ? rcst_pkg::AUX_HIGH : rcst_pkg::AUX_LOW;
        f.aux2 = aux2_hi ? rcst_pkg::AUX_HIGH : rcst_pkg::AUX_LOW;
        f.mode = mode_now;
        f.changed = chg;
        return f;
    endfunction

    // clock and timeout
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout: %0d frames outstanding", frame_queue.size());
        $display("rc_stick_channel_trim_processor test failed");
        $finish;
    end

    // random gap: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // driver: presents queued ticks, predicts each one as its transfer happens
    int src_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cur <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                frame_queue.push_back(predict_frame(cur));
                ticks_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    cur <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                    if (src_wait_on) src_gap <= gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result transfer with the oldest prediction
    int sink_gap = 0;
    bit sink_wait_on = 1;
    always @(posedge clk or negedge rst_n)
    begin
        frame_t exp_f;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                frames_seen++;
                if (frame_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer at %0t", $time);
                end
                else
                begin
                    exp_f = frame_queue.pop_front();
                    if (exp_f.changed) trim_pulses++;
                    if (got !== exp_f)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: exp r%0d p%0d y%0d t%0d a%0d/%0d m%0d c%0d",
                                      " got r%0d p%0d y%0d t%0d a%0d/%0d m%0d c%0d"}, $time,
                                     exp_f.roll, exp_f.pitch, exp_f.yaw, exp_f.thr,
                                     exp_f.aux1, exp_f.aux2, exp_f.mode, exp_f.changed,
                                     got.roll, got.pitch, got.yaw, got.thr,
                                     got.aux1, got.aux2, got.mode, got.changed);
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                out_stall <= 1'b1;
            end
            else if (sink_wait_on && $urandom_range(0, 3) == 0)
            begin
                sink_gap <= gap_len();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // register write driven at one rising edge and taken at the next
    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rcst_pkg::REG_START_MODE)
            mode_now = (val[1:0] == 2'd3) ? rcst_pkg::MODE_NONE : val[1:0];
        else if (idx <= rcst_pkg::REG_TRIM_THR)
            trim[idx - 1] = clamp(int'($signed(val)), -500, 500);
    endtask

    task automatic wait_idle();
        while (tick_queue.size() > 0 || in_valid || frame_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic tick_t rand_tick();
        tick_t t;
        t.roll = 12'($urandom); t.pitch = 12'($urandom);
        t.yaw = 12'($urandom); t.thr = 12'($urandom);
        t.kl = 12'($urandom); t.kr = 12'($urandom);
        t.tx = 12'(int'($urandom_range(0, 3600)) - 1800);
        t.ty = 12'(int'($urandom_range(0, 3600)) - 1800);
        return t;
    endfunction

    // key voltage inside one window of the chosen ladder
    function automatic logic [11:0] key_in(bit right, int w);
        if (!right)
            case (w)
                0: return 12'($urandom_range(0, 99));
                1: return 12'($urandom_range(1951, 2099));
                2: return 12'($urandom_range(2651, 2749));
                3: return 12'($urandom_range(3001, 3099));
                default: return 12'($urandom_range(3201, 3299));
            endcase
        case (w)
            0: return 12'($urandom_range(0, 99));
            1: return 12'($urandom_range(1901, 2099));
            2: return 12'($urandom_range(2601, 2799));
            3: return 12'($urandom_range(2951, 3149));
            4: return 12'($urandom_range(3201, 3299));
            default: return 12'($urandom_range(3351, 3449));
        endcase
    endfunction

    // release both keys to arm, then hold one key for the given number of ticks
    task automatic queue_press(bit right, int w, int hold);
        tick_t t;
        t = rand_tick();
        t.kl = 12'($urandom_range(4051, 4095));
        t.kr = 12'($urandom_range(4051, 4095));
        tick_queue.push_back(t);
        for (int i = 0; i < hold; i++)
        begin
            t = rand_tick();
            if (right)
            begin
                t.kl = 12'($urandom_range(3500, 4050));
                t.kr = key_in(1, w);
            end
            else
            begin
                t.kl = key_in(0, w);
                t.kr = 12'($urandom_range(0, 4095));
            end
            tick_queue.push_back(t);
        end
    endtask

    initial
    begin
        tick_t t;
        int phase_items;
        int hold_len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_wait_on = 1;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes
        t = '0; t.kl = 12'hfff; t.kr = 12'hfff; t.tx = -12'sd1800; t.ty = 12'sd1800;
        tick_queue.push_back(t);
        t = '1; t.tx = 12'sd1800; t.ty = -12'sd1800;
        tick_queue.push_back(t);
        t = '1; t.tx = -12'sd1; t.ty = -12'sd2048;
        tick_queue.push_back(t);
        // every left and right action and the no-op loading key
        for (int w = 0; w < 5; w++) queue_press(0, w, KEY_DELAY + 1);
        for (int w = 0; w < 6; w++) queue_press(1, w, KEY_DELAY + 1);
        wait_idle();

        // a trim step at its upper limit, tilt mode
        src_wait_on = 0;
        write_reg(rcst_pkg::REG_TRIM_THR, 10'sd500);
        write_reg(rcst_pkg::REG_TRIM_ROLL, -10'sd500);
        write_reg(rcst_pkg::REG_TRIM_PITCH, 10'sd499);
        write_reg(rcst_pkg::REG_TRIM_YAW, 10'h200);   // -512 saturates to -500
        write_reg(rcst_pkg::REG_START_MODE, 10'(rcst_pkg::MODE_TILT));
        src_wait_on = 1;
        queue_press(0, 2, KEY_DELAY + 1);
        queue_press(1, 3, KEY_DELAY + 1);
        queue_press(1, 0, KEY_DELAY + 1);
        wait_idle();

        // random phases across register settings, neither mode and code three included
        for (int ph = 0; ph < 8; ph++)
        begin
            src_wait_on = 0;
            write_reg(rcst_pkg::REG_START_MODE, 10'(ph % 4));
            for (int r = 1; r <= 4; r++)
                write_reg(3'(r), 10'($urandom_range(0, 1023)));
            if (ph == 7) write_reg(3'd5, 10'h155);   // unused index, no effect
            src_wait_on = 1;
            phase_items = 0;
            while (phase_items < 180)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    hold_len = $urandom_range(1, KEY_DELAY + 3);
                    queue_press(1'($urandom_range(0, 1)), $urandom_range(0, 5), hold_len);
                    phase_items += hold_len + 1;
                end
                else
                begin
                    tick_queue.push_back(rand_tick());
                    phase_items++;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d ticks sent, %0d results checked, %0d trim saves, %0d mismatches",
                 ticks_sent, frames_seen, trim_pulses, mismatches);
        if (mismatches == 0 && frame_queue.size() == 0)
            $display("rc_stick_channel_trim_processor test passed");
        else
            $display("rc_stick_channel_trim_processor test failed");
        $finish;
    end

endmodule

### rc_stick_channel_trim_processor.f
rtl/rcst_pkg.sv
rtl/rcst_ctrl.sv
rtl/rcst_datapath.sv
rtl/rc_stick_channel_trim_processor.sv
tb/sv/rc_stick_channel_trim_processor_tb.sv
